// File: sv/cfr_pkg.sv
// Shared types and constants for the command frame receiver.
// No dependencies; imported by every module of the block.
package cfr_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned COUNT_W  = 32;
   localparam int unsigned FLAGS_W  = 6;
   localparam int unsigned CMD_W    = 3;

   // Header layout
   localparam logic [BYTE_W-1:0] POS_FLAGS  = 8'd4;
   localparam logic [BYTE_W-1:0] POS_LENGTH = 8'd5;
   localparam logic [BYTE_W-1:0] MIN_LENGTH = 8'd7;

   // Flag byte bit positions
   localparam int unsigned FLAG_SLEEP  = 0;
   localparam int unsigned FLAG_STATUS = 1;
   localparam int unsigned FLAG_DRIVE  = 2;
   localparam int unsigned FLAG_CLAW   = 3;
   localparam int unsigned FLAG_ARM    = 4;
   localparam int unsigned FLAG_ACK    = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_NONE  = 3'd0,
      CMD_SLEEP = 3'd1,
      CMD_DRIVE = 3'd2,
      CMD_CLAW  = 3'd3,
      CMD_ARM   = 3'd4
   } cmd_type;

   typedef struct packed {
      logic               body_valid;
      logic [BYTE_W-1:0]  body_byte;
      logic               frame_end;
      logic [COUNT_W-1:0] packet_count;
      logic [CMD_W-1:0]   command;
      logic               status_flag;
      logic               ack_flag;
      logic [BYTE_W-1:0]  frame_length;
      logic               check_ok;
      logic               length_error;
   } result_type;

   function automatic logic [3:0] ones_in_byte(input logic [BYTE_W-1:0] b);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < BYTE_W; i++) begin
         n = n + {3'b000, b[i]};
      end
      return n;
   endfunction

   function automatic cmd_type decode_command(input logic [FLAGS_W-1:0] f);
      cmd_type c;
      if (f[FLAG_SLEEP]) begin
         c = CMD_SLEEP;
      end else if (f[FLAG_DRIVE]) begin
         c = CMD_DRIVE;
      end else if (f[FLAG_CLAW]) begin
         c = CMD_CLAW;
      end else if (f[FLAG_ARM]) begin
         c = CMD_ARM;
      end else begin
         c = CMD_NONE;
      end
      return c;
   endfunction

endpackage

// File: sv/cfr_parse.sv
// Frame parser: header capture, running set-bit count and per-byte result.
// Depends on cfr_pkg.
module cfr_parse import cfr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic [BYTE_W-1:0] data_byte,
   output result_type        result
);

   logic [BYTE_W-1:0]  pos_ff,   pos_in;
   logic [BYTE_W-1:0]  len_ff,   len_in;
   logic [BYTE_W-1:0]  ones_ff,  ones_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [FLAGS_W-1:0] flags_ff, flags_in;

   logic [BYTE_W-1:0]  ones_sum;
   logic [BYTE_W:0]    pos_next;
   logic               is_check;

   assign ones_sum = ones_ff + {4'b0000, ones_in_byte(data_byte)};
   assign pos_next = {1'b0, pos_ff} + 9'd1;
   assign is_check = pos_next >= {1'b0, len_ff};

   always_comb begin
      pos_in   = pos_ff;
      len_in   = len_ff;
      ones_in  = ones_ff;
      count_in = count_ff;
      flags_in = flags_ff;
      result   = '0;

      if (pos_ff < POS_FLAGS) begin
         count_in = {data_byte, count_ff[COUNT_W-1:BYTE_W]};
         ones_in  = ones_sum;
         pos_in   = pos_next[BYTE_W-1:0];
      end else if (pos_ff == POS_FLAGS) begin
         flags_in = data_byte[FLAGS_W-1:0];
         ones_in  = ones_sum;
         pos_in   = pos_next[BYTE_W-1:0];
      end else if (pos_ff == POS_LENGTH) begin
         len_in  = data_byte;
         ones_in = ones_sum;
         if (data_byte < MIN_LENGTH) begin
            // short frame: report right after the header
            result.frame_end    = 1'b1;
            result.packet_count = count_ff;
            result.command      = decode_command(flags_ff);
            result.status_flag  = flags_ff[FLAG_STATUS];
            result.ack_flag     = flags_ff[FLAG_ACK];
            result.frame_length = data_byte;
            result.length_error = 1'b1;
            pos_in  = '0;
            ones_in = '0;
         end else begin
            pos_in = pos_next[BYTE_W-1:0];
         end
      end else if (is_check) begin
         result.frame_end    = 1'b1;
         result.packet_count = count_ff;
         result.command      = decode_command(flags_ff);
         result.status_flag  = flags_ff[FLAG_STATUS];
         result.ack_flag     = flags_ff[FLAG_ACK];
         result.frame_length = len_ff;
         result.check_ok     = (ones_ff == data_byte);
         pos_in  = '0;
         ones_in = '0;
      end else begin
         result.body_valid = 1'b1;
         result.body_byte  = data_byte;
         ones_in = ones_sum;
         pos_in  = pos_next[BYTE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         len_ff   <= '0;
         ones_ff  <= '0;
         count_ff <= '0;
         flags_ff <= '0;
      end else if (fire) begin
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         ones_ff  <= ones_in;
         count_ff <= count_in;
         flags_ff <= flags_in;
      end
   end

endmodule

// File: sv/cfr_skid.sv
// Two-entry output stage: result register plus skid entry, registered stall.
// Depends on cfr_pkg.
module cfr_skid import cfr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_stall,
   input  result_type in_data,
   output logic       out_valid,
   input  logic       out_stall,
   output result_type out_data
);

   logic       main_vld_ff, main_vld_in;
   logic       skid_vld_ff, skid_vld_in;
   result_type main_ff,     main_in;
   result_type skid_ff,     skid_in;
   logic       take;
   logic       put;

   assign in_stall  = skid_vld_ff;
   assign out_valid = main_vld_ff;
   assign out_data  = main_ff;
   assign take      = main_vld_ff && !out_stall;
   assign put       = in_valid && !skid_vld_ff;

   always_comb begin
      main_vld_in = main_vld_ff;
      skid_vld_in = skid_vld_ff;
      main_in     = main_ff;
      skid_in     = skid_ff;
      if (skid_vld_ff) begin
         if (take) begin
            main_in     = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (put) begin
         if (!main_vld_ff || take) begin
            main_in     = in_data;
            main_vld_in = 1'b1;
         end else begin
            skid_in     = in_data;
            skid_vld_in = 1'b1;
         end
      end else if (take) begin
         main_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         main_vld_ff <= main_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

// File: sv/command_frame_receiver.sv
// Command frame receiver top level: input register, parser, output stage.
// Depends on cfr_pkg, cfr_parse and cfr_skid.
//
// Usage:
//   req_* carries one frame byte per beat; rsp_* returns exactly one result
//   beat per request beat, in order. Frame: 4-byte little-endian packet
//   count, flag byte, length byte L, L-7 body bytes, check byte. Body
//   bytes come back with rsp_body_valid set; the check byte (or the length
//   byte when L < 7, with rsp_length_error) comes back with rsp_frame_end
//   and the summary fields, which are zero on every other beat.
//   Path: request beat into the input register, then parse logic into the
//   output register.
//   Throughput: one byte per cycle while req_stall is low; the parser state
//   updates on each accepted byte, so bytes may arrive back to back.
//   Stall: rsp_stall holds the output register; a skid entry absorbs one
//   more result, after which req_stall rises (from registers only) until
//   the receiver drains it. Nothing is dropped.
//   Reset: synchronous, clears all valids and the parser state; the next
//   byte is taken as byte 0 of a new frame.
module command_frame_receiver import cfr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [BYTE_W-1:0]  req_data_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_body_valid,
   output logic [BYTE_W-1:0]  rsp_body_byte,
   output logic               rsp_frame_end,
   output logic [COUNT_W-1:0] rsp_packet_count,
   output logic [CMD_W-1:0]   rsp_command,
   output logic               rsp_status_flag,
   output logic               rsp_ack_flag,
   output logic [BYTE_W-1:0]  rsp_frame_length,
   output logic               rsp_check_ok,
   output logic               rsp_length_error
);

   logic              in_vld_ff, in_vld_in;
   logic [BYTE_W-1:0] byte_ff,   byte_in;
   logic              out_full;
   logic              fire;
   logic              req_take;
   result_type        parse_res;
   result_type        rsp_res;

   assign fire      = in_vld_ff && !out_full;
   assign req_stall = in_vld_ff && out_full;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_vld_in = in_vld_ff;
      byte_in   = byte_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
         byte_in   = req_data_byte;
      end else if (fire) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
      byte_ff <= byte_in;
   end

   cfr_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .data_byte (byte_ff),
      .result    (parse_res)
   );

   cfr_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fire),
      .in_stall  (out_full),
      .in_data   (parse_res),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_res)
   );

   assign rsp_body_valid   = rsp_res.body_valid;
   assign rsp_body_byte    = rsp_res.body_byte;
   assign rsp_frame_end    = rsp_res.frame_end;
   assign rsp_packet_count = rsp_res.packet_count;
   assign rsp_command      = rsp_res.command;
   assign rsp_status_flag  = rsp_res.status_flag;
   assign rsp_ack_flag     = rsp_res.ack_flag;
   assign rsp_frame_length = rsp_res.frame_length;
   assign rsp_check_ok     = rsp_res.check_ok;
   assign rsp_length_error = rsp_res.length_error;

endmodule

// File: sv/cfr_checker.sv
// Port-level checks for the command frame receiver, bound to the top level.
// Depends on cfr_pkg and command_frame_receiver.
module cfr_checker import cfr_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_body_valid,
   input logic [BYTE_W-1:0]  rsp_body_byte,
   input logic               rsp_frame_end,
   input logic [COUNT_W-1:0] rsp_packet_count,
   input logic [CMD_W-1:0]   rsp_command,
   input logic               rsp_status_flag,
   input logic               rsp_ack_flag,
   input logic [BYTE_W-1:0]  rsp_frame_length,
   input logic               rsp_check_ok,
   input logic               rsp_length_error
);

   // a held result beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped under stall");

   // body and frame end never share a beat; body byte is zero off body beats
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_body_valid && rsp_frame_end) &&
         (rsp_body_valid || rsp_body_byte == '0))
      else $error("beat kind or body byte inconsistent");

   a_summary_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_end |->
         rsp_packet_count == '0 && rsp_command == CMD_NONE && !rsp_status_flag &&
         !rsp_ack_flag && rsp_frame_length == '0 && !rsp_check_ok && !rsp_length_error)
      else $error("summary fields set outside frame end");

   a_short_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_length_error |->
         rsp_frame_end && !rsp_check_ok && rsp_frame_length < MIN_LENGTH)
      else $error("length error inconsistent");

   // an empty output stage fills only from an accepted request beat, via the input register
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result beat without request");

endmodule

bind command_frame_receiver cfr_checker u_cfr_checker (.*);
